[src/sfm_pkg.sv]
// Shared constants, types and helpers for the secp256k1 field multiplier.
package sfm_pkg;

   localparam int LIMB_BITS = 32;
   localparam int NUM_LIMBS = 8;
   localparam int NUM_ROWS = NUM_LIMBS;
   localparam int NUM_REDUCE_STAGES = 6;
   localparam int NUM_STAGES = NUM_ROWS + NUM_REDUCE_STAGES;

   localparam logic [255:0] PRIME =
      256'hffffffff_ffffffff_ffffffff_ffffffff_ffffffff_ffffffff_fffffffe_fffffc2f;
   localparam logic [32:0] FOLD_K = 33'h1_000003d1;
   localparam logic [9:0] FOLD_K_LOW = 10'd977;

   typedef logic [NUM_LIMBS-1:0][63:0] row_prods_type;

   // Sum of eight 64-bit partial products placed 32 bits apart.
   function automatic logic [287:0] row_sum(input row_prods_type prods);
      logic [255:0] even_part;
      logic [255:0] odd_part;
      for (int j = 0; j < NUM_LIMBS / 2; j++) begin
         even_part[j*64 +: 64] = prods[2*j];
         odd_part[j*64 +: 64] = prods[2*j+1];
      end
      return {32'b0, even_part} + {odd_part, 32'b0};
   endfunction

endpackage

[src/sfm_if.sv]
// Valid/ready channel interfaces for operand and result transactions.
interface sfm_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] a_word0;
   logic [63:0] a_word1;
   logic [63:0] a_word2;
   logic [63:0] a_word3;
   logic [63:0] b_word0;
   logic [63:0] b_word1;
   logic [63:0] b_word2;
   logic [63:0] b_word3;

   modport source (output valid, a_word0, a_word1, a_word2, a_word3,
                   b_word0, b_word1, b_word2, b_word3, input ready);
   modport sink (input valid, a_word0, a_word1, a_word2, a_word3,
                 b_word0, b_word1, b_word2, b_word3, output ready);
endinterface

interface sfm_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] r_word0;
   logic [63:0] r_word1;
   logic [63:0] r_word2;
   logic [63:0] r_word3;

   modport source (output valid, r_word0, r_word1, r_word2, r_word3, input ready);
   modport sink (input valid, r_word0, r_word1, r_word2, r_word3, output ready);
endinterface

[src/sfm_mul_cell.sv]
// One row cell: multiplies one 32-bit limb of a by all of b and accumulates
// the row products handed over by the previous cell.
module sfm_mul_cell
   import sfm_pkg::*;
#(
   parameter int ROW = 0
) (
   input  logic          clock,
   input  logic          load,
   input  logic [255:0]  a_in,
   input  logic [255:0]  b_in,
   input  logic [511:0]  acc_in,
   input  row_prods_type prods_in,
   output logic [255:0]  a_out,
   output logic [255:0]  b_out,
   output logic [511:0]  acc_out,
   output row_prods_type prods_out
);

   localparam int SHIFT = (ROW == 0) ? 0 : LIMB_BITS * (ROW - 1);

   logic [255:0]  a_ff, b_ff;
   logic [511:0]  acc_ff, acc_in_w;
   row_prods_type prods_ff, prods_in_w;
   logic [31:0]   a_limb;

   // Partial products of this row, one 32x32 multiplier per limb of b.
   assign a_limb = a_in[ROW*LIMB_BITS +: LIMB_BITS];
   always_comb begin
      for (int j = 0; j < NUM_LIMBS; j++) begin
         prods_in_w[j] = {32'b0, a_limb} * {32'b0, b_in[j*LIMB_BITS +: LIMB_BITS]};
      end
   end

   // The previous row's registered products join the running sum.
   assign acc_in_w = acc_in + ({224'b0, row_sum(prods_in)} << SHIFT);

   always_ff @(posedge clock) begin
      if (load) begin
         a_ff <= a_in;
         b_ff <= b_in;
         acc_ff <= acc_in_w;
         prods_ff <= prods_in_w;
      end
   end

   assign a_out = a_ff;
   assign b_out = b_ff;
   assign acc_out = acc_ff;
   assign prods_out = prods_ff;

endmodule

[src/sfm_reduce.sv]
// Reduction stages: last row sum, two folds by 2^32 + 977, carry fold and
// final conditional subtraction of p.
module sfm_reduce
   import sfm_pkg::*;
(
   input  logic                         clock,
   input  logic [NUM_REDUCE_STAGES-1:0] load,
   input  logic [511:0]                 acc_in,
   input  row_prods_type                prods_in,
   output logic [255:0]                 result
);

   logic [511:0]  full_ff;
   logic [255:0]  low_ff, high_ff;
   row_prods_type mul_ff, mul_in;
   logic [290:0]  s_ff, s_in;
   logic [256:0]  s2_ff, s2_in;
   logic [34:0]   excess;
   logic [255:0]  s3_ff, s3_in;
   logic [255:0]  r_ff, r_in;
   logic [255:0]  even_part, odd_part;

   // Upper half limbs times the low part of the fold constant.
   always_comb begin
      for (int j = 0; j < NUM_LIMBS; j++) begin
         mul_in[j] = {32'b0, full_ff[256 + j*LIMB_BITS +: LIMB_BITS]} *
                     {54'b0, FOLD_K_LOW};
      end
   end

   // First fold: low + high * 2^32 + high * 977.
   always_comb begin
      for (int j = 0; j < NUM_LIMBS / 2; j++) begin
         even_part[j*64 +: 64] = mul_ff[2*j];
         odd_part[j*64 +: 64] = mul_ff[2*j+1];
      end
      s_in = {35'b0, low_ff} + {3'b0, high_ff, 32'b0} +
             {35'b0, even_part} + {3'b0, odd_part, 32'b0};
   end

   // Second fold of the excess above bit 255.
   assign excess = s_ff[290:256];
   assign s2_in = {1'b0, s_ff[255:0]} + {190'b0, excess, 32'b0} +
                  {212'b0, {10'b0, excess} * {35'b0, FOLD_K_LOW}};

   // Third fold of the last carry; the sum stays below 2^256.
   assign s3_in = s2_ff[255:0] + (s2_ff[256] ? {223'b0, FOLD_K} : 256'b0);

   // One conditional subtraction leaves the value below p.
   assign r_in = (s3_ff >= PRIME) ? s3_ff - PRIME : s3_ff;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         full_ff <= acc_in + ({224'b0, row_sum(prods_in)} << (LIMB_BITS * (NUM_ROWS - 1)));
      end
      if (load[1]) begin
         mul_ff <= mul_in;
         low_ff <= full_ff[255:0];
         high_ff <= full_ff[511:256];
      end
      if (load[2]) begin
         s_ff <= s_in;
      end
      if (load[3]) begin
         s2_ff <= s2_in;
      end
      if (load[4]) begin
         s3_ff <= s3_in;
      end
      if (load[5]) begin
         r_ff <= r_in;
      end
   end

   assign result = r_ff;

endmodule

[src/secp256k1_field_multiplier.sv]
// Top level: pipelined secp256k1 field multiplier, a*b mod p.
// Eight row cells followed by six reduction stages lie between an accepted
// operand transaction and its result.
// Throughput: one transaction per cycle while the output is not stalled; a stalled
// stage holds only the stages behind it up to the first empty one, which keeps filling.
// Reset clears all stage valid bits synchronously; payload is not reset.
module secp256k1_field_multiplier
   import sfm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   sfm_req_if.sink      req_chan,
   sfm_rsp_if.source    rsp_chan
);

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES:0]   ready;
   logic [255:0]          a_chain [NUM_ROWS+1];
   logic [255:0]          b_chain [NUM_ROWS+1];
   logic [511:0]          acc_chain [NUM_ROWS+1];
   row_prods_type         prods_chain [NUM_ROWS+1];
   logic [255:0]          result;

   // A stage takes new data when it is empty or its successor moves on.
   always_comb begin
      ready[NUM_STAGES] = rsp_chan.ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (ready[k]) begin
            valid_in[k] = (k == 0) ? req_chan.valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Operands enter the first cell with an empty sum.
   assign a_chain[0] = {req_chan.a_word3, req_chan.a_word2, req_chan.a_word1, req_chan.a_word0};
   assign b_chain[0] = {req_chan.b_word3, req_chan.b_word2, req_chan.b_word1, req_chan.b_word0};
   assign acc_chain[0] = '0;
   assign prods_chain[0] = '0;

   // Row of multiply-accumulate cells.
   for (genvar k = 0; k < NUM_ROWS; k++) begin : g_row
      sfm_mul_cell #(
         .ROW(k)
      ) u_cell (
         .clock    (clock),
         .load     (ready[k]),
         .a_in     (a_chain[k]),
         .b_in     (b_chain[k]),
         .acc_in   (acc_chain[k]),
         .prods_in (prods_chain[k]),
         .a_out    (a_chain[k+1]),
         .b_out    (b_chain[k+1]),
         .acc_out  (acc_chain[k+1]),
         .prods_out(prods_chain[k+1])
      );
   end

   // Reduction modulo p.
   sfm_reduce u_reduce (
      .clock   (clock),
      .load    (ready[NUM_STAGES-1:NUM_ROWS]),
      .acc_in  (acc_chain[NUM_ROWS]),
      .prods_in(prods_chain[NUM_ROWS]),
      .result  (result)
   );

   assign req_chan.ready = ready[0];
   assign rsp_chan.valid = valid_ff[NUM_STAGES-1];
   assign rsp_chan.r_word0 = result[63:0];
   assign rsp_chan.r_word1 = result[127:64];
   assign rsp_chan.r_word2 = result[191:128];
   assign rsp_chan.r_word3 = result[255:192];

`ifndef NO_ASSERTIONS
   // A delivered result is always fully reduced.
   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (result < PRIME))
      else $error("result not below p");

   // With the output stage empty the whole pipeline can take a transaction.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("input stalled while output empty");

   // Nothing is presented in the cycle after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid right after reset");
`endif

endmodule
